FILE: hw/rtl/tuner_meter_frame_parser_macros.svh
// -----------------------------------------------------------------------------
// tuner_meter_frame_parser_macros.svh
// Assertion shorthands for the tuner meter frame parser, clocked on clk and
// held off while arst_n is low.
// -----------------------------------------------------------------------------
`ifndef TUNER_METER_FRAME_PARSER_MACROS_SVH
`define TUNER_METER_FRAME_PARSER_MACROS_SVH

// same-cycle implication
`define TMFP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define TMFP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/tmfp_pkg.sv
// -----------------------------------------------------------------------------
// tmfp_pkg
// Types, codes and band table shared by the tuner meter frame parser.
// -----------------------------------------------------------------------------
`default_nettype none

package tmfp_pkg;

	localparam int FRAME_LEN_DEF = 6;
	localparam int FRAME_LEN_MIN = 6;   // words are taken from bytes 0..5

	localparam logic [7:0] END_MARK  = 8'h3B;
	localparam logic [7:0] REPLY_MIN = 8'h30;

	localparam logic [1:0] ACT_BYTE     = 2'd0;
	localparam logic [1:0] ACT_METER    = 2'd1;
	localparam logic [1:0] ACT_RESPONSE = 2'd2;

	localparam logic [1:0] MARKS_PER_FRAME = 2'd2;

	localparam int         NUM_BANDS = 11;
	localparam logic [3:0] BAND_NONE = 4'd11;

	typedef logic [15:0] band_lim_t [NUM_BANDS];

	localparam band_lim_t BAND_LO = '{16'd8230, 16'd4110, 16'd3060, 16'd2250,
		16'd1600, 16'd1140, 16'd900, 16'd766, 16'd655, 16'd550, 16'd320};
	localparam band_lim_t BAND_HI = '{16'd9145, 16'd4710, 16'd3080, 16'd2355,
		16'd1630, 16'd1180, 16'd915, 16'd782, 16'd662, 16'd590, 16'd360};

	typedef enum logic [1:0] {
		KIND_REPLY     = 2'd0,
		KIND_REPLY_ERR = 2'd1,
		KIND_FRAME     = 2'd2,
		KIND_FRAME_ERR = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		LS_RESPONSE = 3'b001,
		LS_METER    = 3'b010,
		LS_RESYNC   = 3'b100
	} listen_t;

	typedef struct packed {
		logic [1:0] action;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  reply_byte;
		logic [15:0] forward_raw;
		logic [15:0] reflected_raw;
		logic [15:0] band_word;
		logic [3:0]  band_code;
	} result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tmfp_band_decode.sv
// -----------------------------------------------------------------------------
// tmfp_band_decode
// Maps the band indicator word onto a band code; first matching range wins.
// -----------------------------------------------------------------------------
`default_nettype none

module tmfp_band_decode (
	input  wire logic [15:0] band_word,
	output logic      [3:0]  band_code
);

	always_comb begin
		band_code = tmfp_pkg::BAND_NONE;
		// walk downwards so the lowest matching index is left standing
		for (int i = tmfp_pkg::NUM_BANDS - 1; i >= 0; i--) begin
			if (band_word >= tmfp_pkg::BAND_LO[i] && band_word <= tmfp_pkg::BAND_HI[i]) begin
				band_code = 4'(i);
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tmfp_frame_core.sv
// -----------------------------------------------------------------------------
// tmfp_frame_core
// Listen state, frame index, marker count and frame byte store. Works out
// the result for the registered item and commits the state on advance.
// -----------------------------------------------------------------------------
`default_nettype none

module tmfp_frame_core #(
	parameter int FRAME_LEN = tmfp_pkg::FRAME_LEN_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire tmfp_pkg::item_t  item,
	input  wire logic             commit,
	output logic                  res_valid,
	output tmfp_pkg::result_t     res
);

	localparam int FIDX_W = $clog2(FRAME_LEN + 1);

	tmfp_pkg::listen_t  state_q, state_d;
	logic [FIDX_W-1:0]  fidx_q, fidx_d;
	logic [1:0]         marks_q, marks_d;
	logic [1:0]         marks_inc;
	logic               wr_en;
	logic [7:0]         frame_q [FRAME_LEN];
	logic [15:0]        band_word;
	logic [3:0]         band_code;

	assign marks_inc = marks_q + 2'd1;
	assign band_word = {frame_q[4], frame_q[5]};

	tmfp_band_decode u_band (
		.band_word (band_word),
		.band_code (band_code)
	);

	always_comb begin
		state_d   = state_q;
		fidx_d    = fidx_q;
		marks_d   = marks_q;
		wr_en     = 1'b0;
		res_valid = 1'b0;
		res       = '0;
		unique case (item.action)
			tmfp_pkg::ACT_METER:    state_d = tmfp_pkg::LS_METER;
			tmfp_pkg::ACT_RESPONSE: state_d = tmfp_pkg::LS_RESPONSE;
			tmfp_pkg::ACT_BYTE: begin
				unique case (state_q)
					tmfp_pkg::LS_RESPONSE: begin
						res_valid = 1'b1;
						if (item.rx_byte >= tmfp_pkg::REPLY_MIN) begin
							res.kind       = tmfp_pkg::KIND_REPLY;
							res.reply_byte = item.rx_byte;
						end else begin
							res.kind = tmfp_pkg::KIND_REPLY_ERR;
						end
					end
					tmfp_pkg::LS_METER: begin
						if (fidx_q < FIDX_W'(FRAME_LEN)) begin
							wr_en  = 1'b1;
							fidx_d = FIDX_W'(fidx_q + 1'b1);
						end else if (item.rx_byte == tmfp_pkg::END_MARK) begin
							if (marks_inc == tmfp_pkg::MARKS_PER_FRAME) begin
								fidx_d            = '0;
								marks_d           = '0;
								res_valid         = 1'b1;
								res.kind          = tmfp_pkg::KIND_FRAME;
								res.forward_raw   = {frame_q[0], frame_q[1]};
								res.reflected_raw = {frame_q[2], frame_q[3]};
								res.band_word     = band_word;
								res.band_code     = band_code;
							end else begin
								marks_d = marks_inc;
							end
						end else begin
							fidx_d    = '0;
							marks_d   = '0;
							state_d   = tmfp_pkg::LS_RESYNC;
							res_valid = 1'b1;
							res.kind  = tmfp_pkg::KIND_FRAME_ERR;
						end
					end
					tmfp_pkg::LS_RESYNC: begin
						if (item.rx_byte == tmfp_pkg::END_MARK) begin
							if (marks_inc >= tmfp_pkg::MARKS_PER_FRAME) begin
								state_d = tmfp_pkg::LS_METER;
								marks_d = '0;
								fidx_d  = '0;
							end else begin
								marks_d = marks_inc;
							end
						end
					end
					default: ;
				endcase
			end
			default: ;  // unused action code
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tmfp_pkg::LS_RESPONSE;
			fidx_q  <= '0;
			marks_q <= '0;
		end else if (commit) begin
			state_q <= state_d;
			fidx_q  <= fidx_d;
			marks_q <= marks_d;
		end
	end

	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_store
		always_ff @(posedge clk) begin
			if (commit && wr_en && fidx_q == FIDX_W'(i)) begin
				frame_q[i] <= item.rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/tuner_meter_frame_parser.sv
// -----------------------------------------------------------------------------
// tuner_meter_frame_parser
// Parses tuner serial bytes into replies, meter frames and framing errors.
//
//   channel  | direction | handshake             | payload
//   ---------+-----------+-----------------------+------------------------------
//   item     | in        | item_valid/item_stall | action, rx_byte
//   result   | out       | result_valid/stall    | result_kind, reply_byte,
//            |           |                       | forward_raw, reflected_raw,
//            |           |                       | band_word, band_code
//
// One beat per cycle while item_stall is low; a result passes the input register
// and then the result register before it reaches the outputs.
// Reset clears the listen state to response mode, frame index and markers.
// The item side stalls only while the input register holds a result-bearing
// beat and the result register is full and stalled.
// -----------------------------------------------------------------------------
`default_nettype none

module tuner_meter_frame_parser #(
	parameter int FRAME_LEN = tmfp_pkg::FRAME_LEN_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  rx_byte,
	output logic             result_valid,
	input  wire logic        result_stall,
	output logic      [1:0]  result_kind,
	output logic      [7:0]  reply_byte,
	output logic      [15:0] forward_raw,
	output logic      [15:0] reflected_raw,
	output logic      [15:0] band_word,
	output logic      [3:0]  band_code
);

`include "tuner_meter_frame_parser_macros.svh"

	logic               valid_s1;
	tmfp_pkg::item_t    item_s1;
	logic               valid_s2;
	tmfp_pkg::result_t  res_s2;
	logic               core_valid;
	tmfp_pkg::result_t  core_res;
	logic               out_free;
	logic               advance;
	logic               accept;

	tmfp_frame_core #(
		.FRAME_LEN (FRAME_LEN)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_s1),
		.commit    (advance),
		.res_valid (core_valid),
		.res       (core_res)
	);

	assign out_free   = !valid_s2 || !result_stall;
	assign advance    = valid_s1 && (!core_valid || out_free);
	assign item_stall = valid_s1 && !advance;
	assign accept     = item_valid && !item_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= '{action: action, rx_byte: rx_byte};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && core_valid) begin
			valid_s2 <= 1'b1;
		end else if (!result_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && core_valid) begin
			res_s2 <= core_res;
		end
	end

	assign result_valid  = valid_s2;
	assign result_kind   = res_s2.kind;
	assign reply_byte    = res_s2.reply_byte;
	assign forward_raw   = res_s2.forward_raw;
	assign reflected_raw = res_s2.reflected_raw;
	assign band_word     = res_s2.band_word;
	assign band_code     = res_s2.band_code;

	`TMFP_ASSERT_NOW(a_stall_cause, item_stall, valid_s1 && valid_s2 && result_stall, "item stalled without a blocked result")
	`TMFP_ASSERT_NOW(a_reply_zero, valid_s2 && res_s2.kind != tmfp_pkg::KIND_REPLY, res_s2.reply_byte == 8'd0, "reply byte set on a non-reply result")
	`TMFP_ASSERT_NOW(a_frame_zero, valid_s2 && res_s2.kind != tmfp_pkg::KIND_FRAME, res_s2.forward_raw == 16'd0 && res_s2.band_code == 4'd0, "frame fields set on a non-frame result")
	`TMFP_ASSERT_NEXT(a_drain, valid_s2 && !result_stall && !valid_s1, !valid_s2, "result register refilled with nothing in flight")

endmodule

`default_nettype wire
